@@ hw/rtl/pcgd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcgd_pkg: shared types and constants of the gray pixel decoder
// Item structs, register indexes, colors and the decode helper functions.
// ----------------------------------------------------------------------------
package pcgd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] CFG_GLYPH_WIDTH      = 2'd0;
    localparam logic [1:0] CFG_GLYPH_HEIGHT     = 2'd1;
    localparam logic [1:0] CFG_TRANSPARENT_MODE = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_END   = 1'b1;

    localparam logic [15:0] COLOR_WHITE = 16'hFFFF;
    localparam logic [15:0] COLOR_KEY   = 16'hF81F;
    localparam logic [15:0] COLOR_BLACK = 16'h0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        item_kind;
        logic [15:0] pixel_index;
        logic [15:0] pixel_color;
        logic        end_of_run;
    } out_item_t;

    // Settings seen by the decoder, derived from the configuration registers.
    typedef struct packed {
        logic [15:0] total;
        logic        transparent;
    } cfg_t;

    // Gray level g maps to v = (15-g)*17, which is the nibble 15-g repeated.
    function automatic logic [15:0] gray_color(input logic [3:0] g);
        logic [3:0] inv;
        logic [7:0] v;
        begin
            inv = 4'hF - g;
            v   = {inv, inv};
            return {v[7:3], v[7:2], v[7:3]};
        end
    endfunction

    // True when the bits below position pos complete at least one more code,
    // starting from the state right after a pixel.
    function automatic logic pixel_ahead(input logic [7:0] data, input logic [2:0] pos);
        logic [2:0] p1;
        logic [2:0] p2;
        begin
            p1 = pos - 3'd1;
            p2 = pos - 3'd2;
            return (pos != 3'd0) &&
                   (!data[p1] || ((pos >= 3'd2) && (!data[p2] || (pos >= 3'd6))));
        end
    endfunction

endpackage

@@ hw/rtl/pcgd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcgd_front: input byte queue
// Accepts bitstream bytes and holds them until the decoder has used them.
// ----------------------------------------------------------------------------
module pcgd_front
    import pcgd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_stall,
    input  in_item_t byte_item,
    output logic     head_valid,
    output in_item_t head_item,
    input  logic     head_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    in_item_t queue_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign byte_stall = (count_reg == CNT_W'(DEPTH));
    assign push       = byte_valid && !byte_stall;
    assign head_valid = (count_reg != '0);
    assign pop        = head_pop && head_valid;
    assign head_item  = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= byte_item;
        end
    end

endmodule

@@ hw/rtl/pcgd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcgd_back: bit-serial prefix code decoder
// Walks the head byte one code bit per cycle unless stalled; registers items.
// ----------------------------------------------------------------------------
module pcgd_back
    import pcgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      head_valid,
    input  in_item_t  head_item,
    output logic      head_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ONE  = 3'b010,
        PH_GRAY = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        ST_BITS   = 3'b001,
        ST_FLUSH  = 3'b010,
        ST_REPORT = 3'b100
    } step_t;

    step_t       step_reg, step_next;
    phase_t      phase_reg, phase_next;
    logic [2:0]  bit_idx_reg, bit_idx_next;
    logic [3:0]  gray_bits_reg, gray_bits_next;
    logic [2:0]  gray_cnt_reg, gray_cnt_next;
    logic [15:0] done_reg, done_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;

    logic        advance;
    logic        full;
    logic        done_after;
    logic        cur_bit;
    logic [15:0] backdrop_color;
    logic [3:0]  gray_shift;
    logic        pix_emit;
    logic [15:0] pix_color;

    assign advance        = head_valid && (!out_valid_reg || !out_stall);
    assign full           = (done_reg >= cfg.total);
    assign done_after     = ({1'b0, done_reg} + 17'd1) >= {1'b0, cfg.total};
    assign cur_bit        = head_item.data_byte[bit_idx_reg];
    assign backdrop_color = cfg.transparent ? COLOR_KEY : COLOR_WHITE;
    assign gray_shift     = {gray_bits_reg[2:0], cur_bit};

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        step_next      = step_reg;
        phase_next     = phase_reg;
        bit_idx_next   = bit_idx_reg;
        gray_bits_next = gray_bits_reg;
        gray_cnt_next  = gray_cnt_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        head_pop       = 1'b0;
        pix_emit       = 1'b0;
        pix_color      = COLOR_BLACK;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            case (step_reg)
                ST_BITS:
                begin
                    if (!full)
                    begin
                        case (phase_reg)
                            PH_ONE:
                            begin
                                if (!cur_bit)
                                begin
                                    pix_emit   = 1'b1;
                                    pix_color  = COLOR_BLACK;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next     = PH_GRAY;
                                    gray_bits_next = '0;
                                    gray_cnt_next  = '0;
                                end
                            end
                            PH_GRAY:
                            begin
                                if (gray_cnt_reg == 3'd3)
                                begin
                                    pix_emit       = 1'b1;
                                    pix_color      = gray_color(gray_shift);
                                    phase_next     = PH_IDLE;
                                    gray_bits_next = '0;
                                    gray_cnt_next  = '0;
                                end
                                else
                                begin
                                    gray_bits_next = gray_shift;
                                    gray_cnt_next  = gray_cnt_reg + 3'd1;
                                end
                            end
                            default:
                            begin
                                if (!cur_bit)
                                begin
                                    pix_emit  = 1'b1;
                                    pix_color = backdrop_color;
                                end
                                else
                                begin
                                    phase_next = PH_ONE;
                                end
                            end
                        endcase
                    end

                    if (pix_emit)
                    begin
                        // The item closes the run unless an end report follows
                        // or this byte's rest completes a code in the glyph.
                        out_valid_next           = 1'b1;
                        out_item_next.item_kind   = KIND_PIXEL;
                        out_item_next.pixel_index = done_reg;
                        out_item_next.pixel_color = pix_color;
                        out_item_next.end_of_run  = !head_item.last_byte &&
                            !(!done_after && pixel_ahead(head_item.data_byte, bit_idx_reg));
                        done_next                 = done_reg + 16'd1;
                    end

                    if (bit_idx_reg == 3'd0)
                    begin
                        bit_idx_next = 3'd7;
                        if (head_item.last_byte)
                        begin
                            step_next = ST_FLUSH;
                        end
                        else
                        begin
                            head_pop = 1'b1;
                        end
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - 3'd1;
                    end
                end
                ST_FLUSH:
                begin
                    // A gray code cut off by the end of the glyph still yields
                    // a pixel from the bits gathered so far.
                    if (!full && (phase_reg == PH_GRAY))
                    begin
                        out_valid_next            = 1'b1;
                        out_item_next.item_kind   = KIND_PIXEL;
                        out_item_next.pixel_index = done_reg;
                        out_item_next.pixel_color = gray_color(gray_bits_reg);
                        out_item_next.end_of_run  = 1'b0;
                        done_next                 = done_reg + 16'd1;
                    end
                    step_next = ST_REPORT;
                end
                ST_REPORT:
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.item_kind   = KIND_END;
                    out_item_next.pixel_index = done_reg;
                    out_item_next.pixel_color = backdrop_color;
                    out_item_next.end_of_run  = 1'b1;
                    phase_next                = PH_IDLE;
                    gray_bits_next            = '0;
                    gray_cnt_next             = '0;
                    done_next                 = '0;
                    head_pop                  = 1'b1;
                    step_next                 = ST_BITS;
                end
                default:
                begin
                    step_next = ST_BITS;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_BITS;
            phase_reg     <= PH_IDLE;
            bit_idx_reg   <= 3'd7;
            gray_bits_reg <= '0;
            gray_cnt_reg  <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            bit_idx_reg   <= bit_idx_next;
            gray_bits_reg <= gray_bits_next;
            gray_cnt_reg  <= gray_cnt_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

@@ hw/rtl/prefix_code_gray_pixel_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_gray_pixel_decoder_core: glyph bitmap to RGB565 pixel decoder
// Queues compressed bytes, decodes them bit-serially and emits pixel items.
// ----------------------------------------------------------------------------
// Path: an accepted byte is written into the queue and decoded from its head;
// each pixel is valid in the cycle after its last code bit.
// Throughput: one code bit per cycle unless the output stalls, plus a flush
// and an end report step for a last byte; a byte queue lets input run ahead.
// Reset: rst_n is asynchronous and active low; it empties the queue, clears
// the decode state and sets all configuration registers to zero.
// ----------------------------------------------------------------------------
module prefix_code_gray_pixel_decoder_core
    import pcgd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_item,
    output logic      pixel_valid,
    input  logic      pixel_stall,
    output out_item_t pixel_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic        transparent_reg;
    logic [15:0] total_reg;
    cfg_t        cfg;

    logic        head_valid;
    in_item_t    head_item;
    logic        head_pop;

    assign cfg_ready       = 1'b1;
    assign cfg.total       = total_reg;
    assign cfg.transparent = transparent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= '0;
            height_reg      <= '0;
            transparent_reg <= 1'b0;
            total_reg       <= '0;
        end
        else
        begin
            total_reg <= {8'd0, width_reg} * {8'd0, height_reg};
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GLYPH_WIDTH:      width_reg       <= cfg_data;
                    CFG_GLYPH_HEIGHT:     height_reg      <= cfg_data;
                    CFG_TRANSPARENT_MODE: transparent_reg <= cfg_data[0];
                    default:              ;
                endcase
            end
        end
    end

    pcgd_front #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop)
    );

    pcgd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop),
        .out_valid  (pixel_valid),
        .out_stall  (pixel_stall),
        .out_item   (pixel_item)
    );

`ifndef NO_ASSERTIONS
    // An end report always closes the run of its byte.
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && (pixel_item.item_kind == KIND_END)) |-> pixel_item.end_of_run)
        else $error("end report without end_of_run");

    // Pixels never run past the glyph area.
    a_pixel_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && (pixel_item.item_kind == KIND_PIXEL))
            |-> (pixel_item.pixel_index < total_reg))
        else $error("pixel index beyond glyph area");

    // A stalled result item stays valid and unchanged.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_stall) |=> (pixel_valid && $stable(pixel_item)))
        else $error("stalled result item changed");
`endif

endmodule

@@ tb/prefix_code_gray_pixel_decoder_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_gray_pixel_decoder_core_test: self-checking bench of the decoder
// Feeds compressed glyph bytes with bursty input and a patterned output stall.
// It predicts every pixel and end report in the bench and compares each
// result field by field, over a directed table and a random glyph phase.
// ----------------------------------------------------------------------------
module prefix_code_gray_pixel_decoder_core_test;
    import pcgd_pkg::*;

    localparam int          HALF_PERIOD    = 6;
    localparam int          RESET_CYCLES   = 6;
    localparam int          RANDOM_ITEMS   = 400;
    localparam int          SETTLE_CYCLES  = 64;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam logic [1:0]  CFG_UNUSED     = 2'd3;

    typedef enum logic [1:0] {PH_IDLE, PH_ONE, PH_GRAY} code_phase_t;
    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [1:0] reg_idx;
        logic [7:0] value;
        logic       last;
        logic       typed;
        out_item_t  result;
    } plan_row_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    in_item_t   byte_item = '0;
    logic       pixel_valid;
    logic       pixel_stall = 1'b0;
    out_item_t  pixel_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    // Bench copy of the registers and of the decode state.
    logic [7:0]  cfg_width = '0;
    logic [7:0]  cfg_height = '0;
    logic        cfg_transparent = 1'b0;
    code_phase_t dec_phase = PH_IDLE;
    logic [3:0]  dec_gray = '0;
    logic [2:0]  dec_gray_count = '0;
    logic [15:0] dec_pixels = '0;

    out_item_t   pending_pixels[$];
    plan_row_t   plan[$];

    int errors = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int glyphs_ended = 0;
    int reg_writes = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int rx_cycle = 0;
    out_item_t want;

    prefix_code_gray_pixel_decoder_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_item   (byte_item),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_item  (pixel_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic logic [15:0] backdrop_color();
        return cfg_transparent ? COLOR_KEY : COLOR_WHITE;
    endfunction

    function automatic logic [15:0] gray_rgb(input logic [3:0] level);
        logic [7:0] v;
        v = 8'((15 - int'(level)) * 17);
        return {v[7:3], v[7:2], v[7:3]};
    endfunction

    function automatic void add_pixel(input logic [15:0] color);
        pending_pixels.push_back('{KIND_PIXEL, dec_pixels, color, 1'b0});
        dec_pixels = dec_pixels + 16'd1;
    endfunction

    // Decodes one byte into the expected pixels and end report, returns their count.
    function automatic int decode_byte(input in_item_t it);
        logic [15:0] total;
        int          first;
        int          b;
        logic        code_bit;
        out_item_t   tail;
        total = {8'd0, cfg_width} * {8'd0, cfg_height};
        first = pending_pixels.size();
        for (b = 7; b >= 0; b--)
        begin
            if (dec_pixels >= total)
                break;
            code_bit = it.data_byte[b];
            case (dec_phase)
                PH_ONE:
                begin
                    if (!code_bit)
                    begin
                        add_pixel(COLOR_BLACK);
                        dec_phase = PH_IDLE;
                    end
                    else
                    begin
                        dec_phase      = PH_GRAY;
                        dec_gray       = '0;
                        dec_gray_count = '0;
                    end
                end
                PH_GRAY:
                begin
                    dec_gray       = {dec_gray[2:0], code_bit};
                    dec_gray_count = dec_gray_count + 3'd1;
                    if (dec_gray_count >= 3'd4)
                    begin
                        add_pixel(gray_rgb(dec_gray));
                        dec_phase      = PH_IDLE;
                        dec_gray       = '0;
                        dec_gray_count = '0;
                    end
                end
                default:
                begin
                    if (!code_bit)
                        add_pixel(backdrop_color());
                    else
                        dec_phase = PH_ONE;
                end
            endcase
        end
        if (it.last_byte)
        begin
            // A gray code cut off by the last byte still yields a pixel.
            if (dec_pixels < total && dec_phase == PH_GRAY)
                add_pixel(gray_rgb(dec_gray));
            pending_pixels.push_back('{KIND_END, dec_pixels, backdrop_color(), 1'b0});
            dec_phase      = PH_IDLE;
            dec_gray       = '0;
            dec_gray_count = '0;
            dec_pixels     = '0;
        end
        if (pending_pixels.size() > first)
        begin
            tail = pending_pixels.pop_back();
            tail.end_of_run = 1'b1;
            pending_pixels.push_back(tail);
        end
        return pending_pixels.size() - first;
    endfunction

    function automatic void compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
        end
    endfunction

    // Holds the sender off until every expected result is out and the queue is quiet.
    task automatic wait_idle();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_GLYPH_WIDTH:      cfg_width = val;
            CFG_GLYPH_HEIGHT:     cfg_height = val;
            CFG_TRANSPARENT_MODE: cfg_transparent = val[0];
            default:              ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(input in_item_t it, input logic typed, input out_item_t given);
        int n;
        int gap;
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_item  <= it;
        do
            @(posedge clk);
        while (byte_stall);
        n = decode_byte(it);
        if (typed)
        begin
            repeat (n) void'(pending_pixels.pop_back());
            pending_pixels.push_back(given);
        end
        bytes_sent++;
        if (it.last_byte)
            glyphs_ended++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                byte_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic plan_cfg(input logic [1:0] idx, input logic [7:0] val);
        plan.push_back('{ROW_CFG, idx, val, 1'b0, 1'b0, '0});
    endtask

    task automatic plan_byte(input logic [7:0] data, input logic last);
        plan.push_back('{ROW_BYTE, 2'd0, data, last, 1'b0, '0});
    endtask

    // A last byte whose only result is an end report known in advance.
    task automatic plan_end(input logic [7:0] data, input logic [15:0] count,
                            input logic [15:0] color);
        plan.push_back('{ROW_BYTE, 2'd0, data, 1'b1, 1'b1, '{KIND_END, count, color, 1'b1}});
    endtask

    // The output side rotates through four stall modes: none, two random rates, a fixed pattern.
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[8:7])
            2'd0:    pixel_stall <= 1'b0;
            2'd1:    pixel_stall <= ($urandom_range(0, 3) == 0);
            2'd2:    pixel_stall <= ($urandom_range(0, 1) == 0);
            default: pixel_stall <= (rx_cycle[2:0] < 3'd3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            results_checked++;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, pixel_item);
            end
            else
            begin
                want = pending_pixels.pop_front();
                compare_field("item_kind", want.item_kind, pixel_item.item_kind);
                compare_field("pixel_index", want.pixel_index, pixel_item.pixel_index);
                compare_field("pixel_color", want.pixel_color, pixel_item.pixel_color);
                compare_field("end_of_run", want.end_of_run, pixel_item.end_of_run);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (pixel_valid && !pixel_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending_pixels.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : main
        int        r;
        int        i;
        int        nbytes;
        int        glyph;
        plan_row_t row;
        in_item_t  it;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table.
        plan_end(8'h00, 16'd0, COLOR_WHITE);           // registers still at reset: empty glyph
        plan_cfg(CFG_GLYPH_WIDTH, 8'd1);
        plan_cfg(CFG_GLYPH_HEIGHT, 8'd1);
        plan_byte(8'h00, 1'b1);
        plan_cfg(CFG_TRANSPARENT_MODE, 8'd1);
        plan_byte(8'h80, 1'b1);
        plan_cfg(CFG_UNUSED, 8'hFF);
        plan_cfg(CFG_GLYPH_WIDTH, 8'd255);
        plan_cfg(CFG_GLYPH_HEIGHT, 8'd255);
        plan_cfg(CFG_TRANSPARENT_MODE, 8'd0);
        plan_byte(8'hFF, 1'b0);
        plan_byte(8'h00, 1'b0);
        plan_byte(8'hAA, 1'b0);
        plan_byte(8'h55, 1'b0);
        plan_byte(8'h01, 1'b1);                        // ends right after a leading one
        plan_byte(8'hF3, 1'b1);                        // gray code cut off with no level bits
        plan_byte(8'h0E, 1'b1);                        // gray code cut off after two level bits
        plan_cfg(CFG_GLYPH_WIDTH, 8'd3);
        plan_cfg(CFG_GLYPH_HEIGHT, 8'd1);
        plan_byte(8'h00, 1'b0);                        // fills the glyph mid-byte
        plan_end(8'hFF, 16'd3, COLOR_WHITE);
        plan_cfg(CFG_GLYPH_WIDTH, 8'd4);
        plan_byte(8'h00, 1'b0);
        plan_cfg(CFG_GLYPH_WIDTH, 8'd2);               // shrinks below the pixels already done
        plan_end(8'h00, 16'd4, COLOR_WHITE);
        plan_cfg(CFG_GLYPH_HEIGHT, 8'd0);
        plan_cfg(CFG_GLYPH_WIDTH, 8'd5);
        plan_end(8'hAA, 16'd0, COLOR_WHITE);

        foreach (plan[k])
        begin
            row = plan[k];
            if (row.kind == ROW_CFG)
                write_reg(row.reg_idx, row.value);
            else
                send_byte('{row.value, row.last}, row.typed, row.result);
        end

        // Random glyphs, mostly small, now and then empty or at full size.
        glyph = 0;
        while (bytes_sent < plan.size() + RANDOM_ITEMS)
        begin
            if (glyph == 0 || $urandom_range(0, 2) == 0)
            begin
                r = $urandom_range(0, 15);
                if (r == 0)
                    write_reg(CFG_GLYPH_WIDTH, 8'd0);
                else if (r == 2 || r == 3)
                    write_reg(CFG_GLYPH_WIDTH, 8'd255);
                else
                    write_reg(CFG_GLYPH_WIDTH, 8'($urandom_range(1, 8)));
                if (r == 1)
                    write_reg(CFG_GLYPH_HEIGHT, 8'd0);
                else if (r == 2)
                    write_reg(CFG_GLYPH_HEIGHT, 8'd255);
                else
                    write_reg(CFG_GLYPH_HEIGHT, 8'($urandom_range(1, 4)));
                if (glyph == 0 || $urandom_range(0, 1) == 0)
                    write_reg(CFG_TRANSPARENT_MODE, 8'($urandom_range(0, 1)));
            end
            nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
            for (i = 0; i < nbytes; i++)
            begin
                if (i > 0 && $urandom_range(0, 29) == 0)
                    write_reg(CFG_GLYPH_HEIGHT, 8'($urandom_range(0, 4)));
                it.data_byte = 8'($urandom_range(0, 255));
                it.last_byte = (i == nbytes - 1);
                send_byte(it, 1'b0, '0);
            end
            glyph++;
        end

        wait_idle();

        $display("Sent %0d bytes over %0d glyph ends with %0d register writes.",
                 bytes_sent, glyphs_ended, reg_writes);
        $display("Checked %0d results, %0d field errors.", results_checked, errors);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pcgd_pkg.sv
hw/rtl/pcgd_front.sv
hw/rtl/pcgd_back.sv
hw/rtl/prefix_code_gray_pixel_decoder_core.sv
tb/prefix_code_gray_pixel_decoder_core_test.sv
